### rtl/qpr_pkg.sv
// ----------------------------------------------------------------------------
// qpr_pkg
// Shared types, widths and helpers for the quaternion product and rotation
// pipeline in signed Q16.16 fixed point.
// ----------------------------------------------------------------------------
`default_nettype none

package qpr_pkg;

  localparam int DataW = 32;
  localparam int OpW   = DataW + 1;
  localparam int FracW = 16;
  localparam int TermW = 2 * OpW - FracW - 1;
  localparam int SumW  = TermW + 2;

  localparam logic signed [OpW-1:0]  OneQ   = OpW'(1) <<< FracW;
  localparam logic signed [SumW-1:0] SatMax = SumW'(signed'({1'b0, {(DataW-1){1'b1}}}));
  localparam logic signed [SumW-1:0] SatMin = SumW'(signed'({1'b1, {(DataW-1){1'b0}}}));

  typedef enum logic [1:0] {
    ACT_PRODUCT  = 2'd0,
    ACT_ROT_QUAT = 2'd1,
    ACT_ROT_VEC  = 2'd2,
    ACT_NONE     = 2'd3
  } action_e;

  typedef logic signed [OpW-1:0]   opnd_t;
  typedef logic signed [TermW-1:0] term_t;
  typedef logic signed [SumW-1:0]  sum_t;
  typedef logic signed [DataW-1:0] data_t;

  typedef struct packed {
    opnd_t x;
    opnd_t y;
    opnd_t z;
    opnd_t w;
  } quat_t;

  typedef struct packed {
    data_t x;
    data_t y;
    data_t z;
    data_t w;
  } res_t;

  typedef struct packed {
    term_t t0;
    term_t t1;
    term_t t2;
    term_t t3;
  } comp_terms_t;

  typedef struct packed {
    comp_terms_t x;
    comp_terms_t y;
    comp_terms_t z;
    comp_terms_t w;
  } terms_t;

  typedef struct packed {
    logic    valid;
    action_e action;
    logic    ovf;
  } ctl_t;

  typedef struct packed {
    logic  ovf;
    data_t val;
  } sat_t;

  function automatic sat_t sat32(input sum_t s);
    sat_t r;
    if (s > SatMax) begin
      r.ovf = 1'b1;
      r.val = data_t'(SatMax);
    end else if (s < SatMin) begin
      r.ovf = 1'b1;
      r.val = data_t'(SatMin);
    end else begin
      r.ovf = 1'b0;
      r.val = s[DataW-1:0];
    end
    return r;
  endfunction

  function automatic term_t qmul(input opnd_t a, input opnd_t b);
    logic signed [2*OpW-1:0] p;
    p = a * b;
    return p[2*OpW-2:FracW];
  endfunction

  function automatic opnd_t widen(input data_t d);
    return OpW'(d);
  endfunction

endpackage

`default_nettype wire

### rtl/qpr_mul_stage.sv
// ----------------------------------------------------------------------------
// qpr_mul_stage
// Forms the sixteen truncated partial products of a Hamilton product u*v
// and registers them together with the item's control bits.
// ----------------------------------------------------------------------------
`default_nettype none

module qpr_mul_stage (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire qpr_pkg::ctl_t  ctl_i,
  input  wire qpr_pkg::quat_t u_i,
  input  wire qpr_pkg::quat_t v_i,
  output qpr_pkg::ctl_t       ctl_o,
  output qpr_pkg::terms_t     terms_o
);
  import qpr_pkg::*;

  ctl_t   ctl_q;
  terms_t terms_d, terms_q;

  always_comb begin
    terms_d.x.t0 = qmul(u_i.w, v_i.x);
    terms_d.x.t1 = qmul(u_i.x, v_i.w);
    terms_d.x.t2 = qmul(u_i.y, v_i.z);
    terms_d.x.t3 = qmul(u_i.z, v_i.y);
    terms_d.y.t0 = qmul(u_i.w, v_i.y);
    terms_d.y.t1 = qmul(u_i.y, v_i.w);
    terms_d.y.t2 = qmul(u_i.z, v_i.x);
    terms_d.y.t3 = qmul(u_i.x, v_i.z);
    terms_d.z.t0 = qmul(u_i.w, v_i.z);
    terms_d.z.t1 = qmul(u_i.z, v_i.w);
    terms_d.z.t2 = qmul(u_i.x, v_i.y);
    terms_d.z.t3 = qmul(u_i.y, v_i.x);
    terms_d.w.t0 = qmul(u_i.w, v_i.w);
    terms_d.w.t1 = qmul(u_i.x, v_i.x);
    terms_d.w.t2 = qmul(u_i.y, v_i.y);
    terms_d.w.t3 = qmul(u_i.z, v_i.z);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.valid) begin
      terms_q <= terms_d;
    end
  end

  assign ctl_o   = ctl_q;
  assign terms_o = terms_q;

endmodule

`default_nettype wire

### rtl/qpr_sum_stage.sv
// ----------------------------------------------------------------------------
// qpr_sum_stage
// Adds the signed partial products of each component, saturates to 32 bits
// and registers the result and running overflow flag; zero_i clears both.
// ----------------------------------------------------------------------------
`default_nettype none

module qpr_sum_stage (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire qpr_pkg::ctl_t   ctl_i,
  input  wire qpr_pkg::terms_t terms_i,
  input  wire logic            skip_w_i,
  input  wire logic            zero_i,
  output qpr_pkg::ctl_t        ctl_o,
  output qpr_pkg::res_t        res_o
);
  import qpr_pkg::*;

  sum_t sx, sy, sz, sw;
  sat_t qx, qy, qz, qw;
  ctl_t ctl_d, ctl_q;
  res_t res_d, res_q;

  always_comb begin
    sx = SumW'(terms_i.x.t0) + SumW'(terms_i.x.t1) + SumW'(terms_i.x.t2)
       - SumW'(terms_i.x.t3);
    sy = SumW'(terms_i.y.t0) + SumW'(terms_i.y.t1) + SumW'(terms_i.y.t2)
       - SumW'(terms_i.y.t3);
    sz = SumW'(terms_i.z.t0) + SumW'(terms_i.z.t1) + SumW'(terms_i.z.t2)
       - SumW'(terms_i.z.t3);
    sw = SumW'(terms_i.w.t0) - SumW'(terms_i.w.t1) - SumW'(terms_i.w.t2)
       - SumW'(terms_i.w.t3);
    qx = sat32(sx);
    qy = sat32(sy);
    qz = sat32(sz);
    qw = sat32(sw);

    ctl_d = ctl_i;
    if (zero_i) begin
      res_d     = '0;
      ctl_d.ovf = 1'b0;
    end else begin
      res_d.x   = qx.val;
      res_d.y   = qy.val;
      res_d.z   = qz.val;
      res_d.w   = skip_w_i ? '0 : qw.val;
      ctl_d.ovf = ctl_i.ovf | qx.ovf | qy.ovf | qz.ovf | (qw.ovf & ~skip_w_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.valid) begin
      res_q <= res_d;
    end
  end

  assign ctl_o = ctl_q;
  assign res_o = res_q;

endmodule

`default_nettype wire

### rtl/quaternion_product_rotate.sv
// ----------------------------------------------------------------------------
// quaternion_product_rotate
// Quaternion Hamilton product and rotation unit in signed Q16.16.
//
// An item is taken at a rising edge where start_i is high and busy_o is low.
// busy_o stays low, so a new item may enter in every cycle. action_i selects
// the Hamilton product A*B, the rotation of quaternion B by A, the
// rotation of the vector part of B by A (result w is zero), or a zero result.
// Each item flows through four register stages: partial products of A*B,
// saturated sums, partial products against conj(A) (or the unit quaternion
// for a plain product), and the final saturated sums. The result appears on
// r_*_o and overflow_o once the item leaves the final sum stage, marked by
// done_o, which is high for a single cycle per item. Throughput is one item
// per cycle, set by the two arrays of sixteen 33x33 multipliers, each of
// which starts a new item every cycle. The receiver cannot stall the block,
// so no item waits. Reset clears every valid bit of the pipeline; items in
// flight are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_product_rotate (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  output logic                      busy_o,
  input  wire logic [1:0]           action_i,
  input  wire qpr_pkg::data_t       a_x_i,
  input  wire qpr_pkg::data_t       a_y_i,
  input  wire qpr_pkg::data_t       a_z_i,
  input  wire qpr_pkg::data_t       a_w_i,
  input  wire qpr_pkg::data_t       b_x_i,
  input  wire qpr_pkg::data_t       b_y_i,
  input  wire qpr_pkg::data_t       b_z_i,
  input  wire qpr_pkg::data_t       b_w_i,
  output logic                      done_o,
  output qpr_pkg::data_t            r_x_o,
  output qpr_pkg::data_t            r_y_o,
  output qpr_pkg::data_t            r_z_o,
  output qpr_pkg::data_t            r_w_o,
  output logic                      overflow_o
);
  import qpr_pkg::*;

  ctl_t   ctl_in, ctl_m1, ctl_s1, ctl_m2, ctl_s2;
  quat_t  a_in, b_in, v2;
  quat_t  a1_q, a2_q;
  quat_t  p1;
  terms_t terms1, terms2;
  res_t   res1, res2;
  logic   skip_w2, zero1, zero2;

  assign busy_o = 1'b0;

  always_comb begin
    ctl_in.valid  = start_i & ~busy_o;
    ctl_in.action = action_e'(action_i);
    ctl_in.ovf    = 1'b0;
    a_in.x = widen(a_x_i);
    a_in.y = widen(a_y_i);
    a_in.z = widen(a_z_i);
    a_in.w = widen(a_w_i);
    b_in.x = widen(b_x_i);
    b_in.y = widen(b_y_i);
    b_in.z = widen(b_z_i);
    b_in.w = (ctl_in.action == ACT_ROT_VEC) ? '0 : widen(b_w_i);
  end

  qpr_mul_stage u_mul1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl_in),
    .u_i     (a_in),
    .v_i     (b_in),
    .ctl_o   (ctl_m1),
    .terms_o (terms1)
  );

  always_ff @(posedge clk_i) begin
    if (ctl_in.valid) begin
      a1_q <= a_in;
    end
    if (ctl_m1.valid) begin
      a2_q <= a1_q;
    end
  end

  assign zero1 = (ctl_m1.action == ACT_NONE);

  qpr_sum_stage u_sum1 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl_m1),
    .terms_i  (terms1),
    .skip_w_i (1'b0),
    .zero_i   (zero1),
    .ctl_o    (ctl_s1),
    .res_o    (res1)
  );

  always_comb begin
    p1.x = widen(res1.x);
    p1.y = widen(res1.y);
    p1.z = widen(res1.z);
    p1.w = widen(res1.w);
    if (ctl_s1.action == ACT_PRODUCT) begin
      v2.x = '0;
      v2.y = '0;
      v2.z = '0;
      v2.w = OneQ;
    end else begin
      v2.x = -a2_q.x;
      v2.y = -a2_q.y;
      v2.z = -a2_q.z;
      v2.w = a2_q.w;
    end
  end

  qpr_mul_stage u_mul2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl_s1),
    .u_i     (p1),
    .v_i     (v2),
    .ctl_o   (ctl_m2),
    .terms_o (terms2)
  );

  assign skip_w2 = (ctl_m2.action == ACT_ROT_VEC);
  assign zero2   = (ctl_m2.action == ACT_NONE);

  qpr_sum_stage u_sum2 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl_m2),
    .terms_i  (terms2),
    .skip_w_i (skip_w2),
    .zero_i   (zero2),
    .ctl_o    (ctl_s2),
    .res_o    (res2)
  );

  assign done_o     = ctl_s2.valid;
  assign overflow_o = ctl_s2.ovf;
  assign r_x_o      = res2.x;
  assign r_y_o      = res2.y;
  assign r_z_o      = res2.z;
  assign r_w_o      = res2.w;

endmodule

`default_nettype wire
